[rtl/core/ffha_pkg.sv]
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared types and status codes of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_OOM     = 2'd1,
        ST_BAD_ADR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE
    } t_op;

endpackage

[rtl/core/ffha_cell.sv]
// ---------------------------------------------------------------------------
// ffha_cell
// One table entry: start, payload size and free flag; shifts with neighbors.
// ---------------------------------------------------------------------------
module ffha_cell #(
    parameter int IDX_W = 6
) (
    input  logic               i_clk,
    input  ffha_pkg::t_op      i_op,
    input  logic [IDX_W-1:0]   i_my_idx,
    input  logic [IDX_W-1:0]   i_tgt_idx,
    input  logic [15:0]        i_new_start,
    input  logic [16:0]        i_new_bytes,
    input  logic               i_new_free,
    input  logic [15:0]        i_left_start,
    input  logic [16:0]        i_left_bytes,
    input  logic               i_left_free,
    input  logic [15:0]        i_right_start,
    input  logic [16:0]        i_right_bytes,
    input  logic               i_right_free,
    output logic [15:0]        o_start,
    output logic [16:0]        o_bytes,
    output logic               o_free
);
    import ffha_pkg::*;

    logic [15:0] r_start;
    logic [16:0] r_bytes;
    logic        r_free;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_WRITE: begin
                if (i_my_idx == i_tgt_idx) begin
                    r_start <= i_new_start;
                    r_bytes <= i_new_bytes;
                    r_free  <= i_new_free;
                end
            end
            OP_INSERT: begin
                if (i_my_idx == i_tgt_idx) begin
                    r_start <= i_new_start;
                    r_bytes <= i_new_bytes;
                    r_free  <= i_new_free;
                end else if (i_my_idx > i_tgt_idx) begin
                    r_start <= i_left_start;
                    r_bytes <= i_left_bytes;
                    r_free  <= i_left_free;
                end
            end
            OP_REMOVE: begin
                if (i_my_idx >= i_tgt_idx) begin
                    r_start <= i_right_start;
                    r_bytes <= i_right_bytes;
                    r_free  <= i_right_free;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_start = r_start;
    assign o_bytes = r_bytes;
    assign o_free  = r_free;

endmodule

[rtl/core/first_fit_heap_allocator_unit.sv]
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over a row of table cells with split and coalesce.
// ---------------------------------------------------------------------------
// channel  direction  signals
// cmd      in         start, busy, i_mode, i_alloc_size, i_free_address
// cfg      in         i_cfg_valid, o_cfg_ready, i_cfg_data
// result   out        o_result_strobe, o_payload_address, o_status
//
// an allocate ends after the scan when out of memory, else takes a scan, one
// row write and a second row write for a split; a free ends after the scan
// for a null or unknown address, else takes a scan, a mark, and may take a next
// removal, a prev write and a self removal; the scan is a parallel priority search
// busy stays high through the strobe cycle; next start is taken the cycle after
// reset clears count and heap top and sets arena limit to 0x10000; table cells need no reset
// the receiver cannot stall the result
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int ARENA_BYTES  = 65536,
    parameter int HEADER_BYTES = 32,
    parameter int MIN_PAYLOAD  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [15:0] i_alloc_size,
    input  logic [15:0] i_free_address,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,
    output logic        o_result_strobe,
    output logic [15:0] o_payload_address,
    output logic [1:0]  o_status
);
    import ffha_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [24:0] LIM_MAX = 25'(ARENA_BYTES);
    localparam logic [16:0] HDR = 17'(HEADER_BYTES);
    localparam logic [16:0] SPLIT_MIN = 17'(HEADER_BYTES + MIN_PAYLOAD);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [16:0] r_top, n_top;
    logic [16:0] r_limit;
    logic r_mode;
    logic [15:0] r_size, r_faddr;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic r_hit, n_hit;
    logic [2:0] r_pend, n_pend; // merge steps (bit0 next remove, bit1 prev write, bit2 self remove)
    logic r_split, n_split;
    logic [15:0] r_addr, n_addr;
    t_status r_st, n_st;
    logic [16:0] r_bytes_left;

    t_op op;
    logic [IDX_W-1:0] tgt;
    logic [15:0] w_start;
    logic [16:0] w_bytes;
    logic w_free;

    logic [15:0] c_start [MAX_BLOCKS];
    logic [16:0] c_bytes [MAX_BLOCKS];
    logic        c_free  [MAX_BLOCKS];

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g == MAX_BLOCKS - 1) ? g : g + 1;
        ffha_cell #(.IDX_W(IDX_W)) u_cell (
            .i_clk        (i_clk),
            .i_op         (op),
            .i_my_idx     (IDX_W'(g)),
            .i_tgt_idx    (tgt),
            .i_new_start  (w_start),
            .i_new_bytes  (w_bytes),
            .i_new_free   (w_free),
            .i_left_start (c_start[L]),
            .i_left_bytes (c_bytes[L]),
            .i_left_free  (c_free[L]),
            .i_right_start(c_start[R]),
            .i_right_bytes(c_bytes[R]),
            .i_right_free (c_free[R]),
            .o_start      (c_start[g]),
            .o_bytes      (c_bytes[g]),
            .o_free       (c_free[g])
        );
    end

    // parallel first-match search
    logic [MAX_BLOCKS-1:0] m_vec;
    logic [IDX_W-1:0] m_idx;
    logic m_any;
    always_comb begin
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (r_mode) begin
                m_vec[k] = (CNT_W'(k) < r_count)
                    && (17'(c_start[k]) + HDR == {1'b0, r_faddr});
            end else begin
                m_vec[k] = (CNT_W'(k) < r_count) && c_free[k]
                    && (c_bytes[k] >= {1'b0, r_size});
            end
        end
        m_any = |m_vec;
        m_idx = '0;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
            if (m_vec[k]) m_idx = IDX_W'(k);
        end
    end

    logic [24:0] lim_eff, app_end;
    logic [16:0] cur_bytes, rest;
    logic [IDX_W-1:0] nxt_i, prv_i;
    logic full;
    always_comb begin
        lim_eff = (25'(r_limit) < LIM_MAX) ? 25'(r_limit) : LIM_MAX;
        app_end = 25'(r_top) + 25'(HDR) + 25'(r_size);
        full = (r_count >= CNT_W'(MAX_BLOCKS));
        cur_bytes = c_bytes[r_idx];
        rest = cur_bytes - {1'b0, r_size};
        nxt_i = r_idx + IDX_W'(1);
        prv_i = r_idx - IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_top   <= '0;
            r_limit <= 17'h10000;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            if (i_cfg_valid && o_cfg_ready) r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode  <= i_mode;
            r_size  <= i_alloc_size;
            r_faddr <= i_free_address;
        end
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_pend  <= n_pend;
        r_split <= n_split;
        r_addr  <= n_addr;
        r_st    <= n_st;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_top = r_top;
        n_idx = r_idx;
        n_hit = r_hit;
        n_pend = r_pend;
        n_split = r_split;
        n_addr = r_addr;
        n_st = r_st;
        op = OP_HOLD;
        tgt = r_idx;
        w_start = c_start[r_idx];
        w_bytes = cur_bytes;
        w_free = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                n_idx = m_idx;
                n_hit = m_any;
                n_addr = '0;
                n_st = ST_DONE;
                n_pend = 3'b000;
                n_split = 1'b0;
                n_state = S_SHIFT;
                if (r_mode && r_faddr == 16'd0) begin
                    n_state = S_RESULT;
                end else if (r_mode && !m_any) begin
                    n_st = ST_BAD_ADR;
                    n_state = S_RESULT;
                end else if (!r_mode && !m_any) begin
                    if (full || app_end > lim_eff || 25'(r_top) + 25'(HDR) > 25'hFFFF)
                    begin
                        n_st = ST_OOM;
                        n_state = S_RESULT;
                    end
                end
            end
            S_SHIFT: begin
                if (!r_mode && !r_hit) begin
                    // append at heap top
                    op = OP_WRITE;
                    tgt = IDX_W'(r_count);
                    w_start = r_top[15:0];
                    w_bytes = {1'b0, r_size};
                    w_free = 1'b0;
                    n_count = r_count + CNT_W'(1);
                    n_addr = r_top[15:0] + HDR[15:0];
                    n_top = app_end[16:0];
                    n_state = S_RESULT;
                end else if (!r_mode && !r_split) begin
                    op = OP_WRITE;
                    w_free = 1'b0;
                    n_addr = c_start[r_idx] + HDR[15:0];
                    if (rest >= SPLIT_MIN && !full) begin
                        w_bytes = {1'b0, r_size};
                        n_split = 1'b1;
                    end else begin
                        n_state = S_RESULT;
                    end
                end else if (!r_mode) begin
                    // insert the leftover after the taken block
                    op = OP_INSERT;
                    tgt = nxt_i;
                    w_start = c_start[r_idx] + HDR[15:0] + r_size;
                    w_bytes = r_bytes_left;
                    w_free = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_RESULT;
                end else if (!r_split) begin
                    // mark free, fold in a free next block, plan the rest
                    op = OP_WRITE;
                    w_free = 1'b1;
                    n_split = 1'b1;
                    n_pend[0] = (CNT_W'(r_idx) + CNT_W'(1) < r_count) && c_free[nxt_i];
                    n_pend[1] = (r_idx != '0) && c_free[prv_i];
                    n_pend[2] = n_pend[1];
                    if (n_pend[0]) w_bytes = cur_bytes + c_bytes[nxt_i] + HDR;
                    if (!n_pend[0] && !n_pend[1]) n_state = S_RESULT;
                end else if (r_pend[0]) begin
                    op = OP_REMOVE;
                    tgt = nxt_i;
                    n_count = r_count - CNT_W'(1);
                    n_pend[0] = 1'b0;
                    if (!r_pend[1]) n_state = S_RESULT;
                end else if (r_pend[1]) begin
                    // grow the free previous block over this one
                    op = OP_WRITE;
                    tgt = prv_i;
                    w_start = c_start[prv_i];
                    w_bytes = c_bytes[prv_i] + cur_bytes + HDR;
                    w_free = 1'b1;
                    n_pend[1] = 1'b0;
                end else begin
                    op = OP_REMOVE;
                    tgt = r_idx;
                    n_count = r_count - CNT_W'(1);
                    n_pend[2] = 1'b0;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // leftover bytes are computed while the block still holds its old size
    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT && !r_mode && r_hit && !r_split)
            r_bytes_left <= rest - HDR;
    end

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_result_strobe = (r_state == S_RESULT);
    assign o_payload_address = r_addr;
    assign o_status = r_st;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> busy)
        else $error("strobe outside busy");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count overflow");
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("strobe longer than one cycle");

endmodule
